/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lie_pkg.sv */
// Package for the list intersection engine: field widths, codes, and the
// command/flag structs between controller and datapath. No dependencies.
`default_nettype none

package lie_pkg;

    localparam int MAX_LEN_DEF  = 1024;
    localparam int ID_WIDTH_DEF = 32;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 3;
    localparam int SEARCH_W = 2;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 21;
    localparam int STATUS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_FIRST  = 3'd0,
        MODE_LOAD_SECOND = 3'd1,
        MODE_RUN         = 3'd2,
        MODE_READ        = 3'd3,
        MODE_CLEAR       = 3'd4
    } in_mode_t;

    typedef enum logic [SEARCH_W-1:0] {
        SM_UNSORTED      = 2'd0,
        SM_SECOND_SORTED = 2'd1,
        SM_BOTH_SORTED   = 2'd2,
        SM_UNKNOWN       = 2'd3
    } search_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_MODE = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_FIRST,
        DP_LOAD_SECOND,
        DP_CLEAR,
        DP_READ,
        DP_RUN_INIT,
        DP_SCAN_RD,
        DP_SCAN_UPD,
        DP_RD_ZERO,
        DP_CAP_LO,
        DP_CAP_HI,
        DP_PAIR_RD,
        DP_PAIR_CMP,
        DP_MRG_RD,
        DP_MRG_CMP
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_UPD,
        S_RD_ZERO,
        S_CAP_LO,
        S_CAP_HI,
        S_OVL_CHK,
        S_PAIR_RD,
        S_PAIR_CMP,
        S_MRG_RD,
        S_MRG_CMP,
        S_RESP_RUN,
        S_RESP_BAD
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    capture;
        logic    out_load;
        status_t out_status;
        logic    out_from_store;
    } dp_cmd_t;

    typedef struct packed {
        logic len1_zero;
        logic len2_zero;
        logic len1_full;
        logic len2_full;
        logic in_range;
        logic overlap;
        logic scan_last;
        logic pair_last;
        logic mrg_done;
        logic overflow;
    } dp_flags_t;

endpackage

`default_nettype wire

/* rtl/lie_datapath.sv */
// Datapath of the list intersection engine: list and match memories,
// lengths, walk counters, range registers and the result register. Uses lie_pkg.
`default_nettype none

module lie_datapath #(
    parameter int MAX_LEN  = lie_pkg::MAX_LEN_DEF,
    parameter int ID_WIDTH = lie_pkg::ID_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lie_pkg::dp_cmd_t              cmd,
    input  wire logic [lie_pkg::VALUE_W-1:0]   in_value,
    output lie_pkg::dp_flags_t                 flags,
    output logic [lie_pkg::INDEX_W-1:0]        out_index,
    output logic [lie_pkg::COUNT_W-1:0]        out_count,
    output lie_pkg::status_t                   out_status
);

    localparam int POS_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int OUT_W = (POS_W > lie_pkg::INDEX_W) ? POS_W : lie_pkg::INDEX_W;
    localparam logic [LEN_W-1:0]            LEN_FULL = LEN_W'(MAX_LEN);
    localparam logic [lie_pkg::COUNT_W-1:0] CNT_CAP  = lie_pkg::COUNT_W'(MAX_LEN);

    logic [ID_WIDTH-1:0] first_mem  [MAX_LEN];
    logic [ID_WIDTH-1:0] second_mem [MAX_LEN];
    logic [POS_W-1:0]    store_mem  [MAX_LEN];

    logic [LEN_W-1:0]            len1_reg, len2_reg;
    logic [lie_pkg::COUNT_W-1:0] found_reg;
    logic                        ovf_reg;
    logic [lie_pkg::VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]            i_reg, j_reg;
    logic [ID_WIDTH-1:0]         lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic [ID_WIDTH-1:0]         a_reg, b_reg;
    logic [POS_W-1:0]            s_reg;
    logic [lie_pkg::INDEX_W-1:0] out_index_reg;
    logic [lie_pkg::COUNT_W-1:0] out_count_reg;
    lie_pkg::status_t            out_status_reg;

    logic [LEN_W-1:0]            len1_m1, len2_m1, max_len, max_len_m1;
    logic [POS_W-1:0]            addr1, addr2;
    logic                        list_rd;
    logic                        i_last, j_last, adv_j, hit;
    logic                        store_room;
    logic [lie_pkg::COUNT_W-1:0] stored_cnt;
    logic [ID_WIDTH-1:0]         load_id;
    logic [OUT_W-1:0]            s_ext;

    assign len1_m1    = len1_reg - LEN_W'(1);
    assign len2_m1    = len2_reg - LEN_W'(1);
    assign max_len    = (len1_reg > len2_reg) ? len1_reg : len2_reg;
    assign max_len_m1 = max_len - LEN_W'(1);
    assign i_last     = (LEN_W'(i_reg) == len1_m1);
    assign j_last     = (LEN_W'(j_reg) == len2_m1);
    assign adv_j      = !j_last && (a_reg > b_reg);
    assign store_room = (found_reg < CNT_CAP);
    assign stored_cnt = store_room ? found_reg : CNT_CAP;
    assign load_id    = ID_WIDTH'(value_reg);
    assign s_ext      = OUT_W'(s_reg);

    always_comb
    begin
        hit = 1'b0;
        case (cmd.op)
            lie_pkg::DP_PAIR_CMP: hit = (a_reg == b_reg);
            lie_pkg::DP_MRG_CMP:  hit = !adv_j && (a_reg == b_reg);
            default:              hit = 1'b0;
        endcase
    end

    // Pick list read addresses for the current step.
    always_comb
    begin
        addr1   = i_reg;
        addr2   = j_reg;
        list_rd = cmd.op inside {lie_pkg::DP_RD_ZERO, lie_pkg::DP_CAP_LO,
                                 lie_pkg::DP_SCAN_RD, lie_pkg::DP_PAIR_RD,
                                 lie_pkg::DP_MRG_RD};
        case (cmd.op)
            lie_pkg::DP_RD_ZERO:
            begin
                addr1 = '0;
                addr2 = '0;
            end
            lie_pkg::DP_CAP_LO:
            begin
                addr1 = len1_m1[POS_W-1:0];
                addr2 = len2_m1[POS_W-1:0];
            end
            lie_pkg::DP_SCAN_RD:
            begin
                addr1 = i_reg;
                addr2 = i_reg;
            end
            default:
            begin
                addr1 = i_reg;
                addr2 = j_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == lie_pkg::DP_LOAD_FIRST && len1_reg != LEN_FULL)
            first_mem[len1_reg[POS_W-1:0]] <= load_id;
        if (list_rd)
            a_reg <= first_mem[addr1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == lie_pkg::DP_LOAD_SECOND && len2_reg != LEN_FULL)
            second_mem[len2_reg[POS_W-1:0]] <= load_id;
        if (list_rd)
            b_reg <= second_mem[addr2];
    end

    always_ff @(posedge clk)
    begin
        if (hit && store_room)
            store_mem[found_reg[POS_W-1:0]] <= i_reg;
        if (cmd.op == lie_pkg::DP_READ)
            s_reg <= store_mem[value_reg[POS_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg  <= '0;
            len2_reg  <= '0;
            found_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                lie_pkg::DP_LOAD_FIRST:
                    if (len1_reg != LEN_FULL)
                        len1_reg <= len1_reg + LEN_W'(1);
                lie_pkg::DP_LOAD_SECOND:
                    if (len2_reg != LEN_FULL)
                        len2_reg <= len2_reg + LEN_W'(1);
                lie_pkg::DP_CLEAR:
                begin
                    len1_reg <= '0;
                    len2_reg <= '0;
                end
                lie_pkg::DP_RUN_INIT:
                begin
                    found_reg <= '0;
                    ovf_reg   <= 1'b0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                end
                lie_pkg::DP_SCAN_UPD:
                    i_reg <= (LEN_W'(i_reg) == max_len_m1) ? '0 : i_reg + POS_W'(1);
                lie_pkg::DP_PAIR_CMP:
                begin
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + POS_W'(1);
                    end
                    else
                        j_reg <= j_reg + POS_W'(1);
                end
                lie_pkg::DP_MRG_CMP:
                begin
                    if (adv_j)
                        j_reg <= j_reg + POS_W'(1);
                    else
                        i_reg <= i_reg + POS_W'(1);
                end
                default:
                begin
                end
            endcase
            // Record a match: store while there is room, always count (saturating).
            if (hit)
            begin
                if (!store_room)
                    ovf_reg <= 1'b1;
                if (found_reg != lie_pkg::COUNT_MAX)
                    found_reg <= found_reg + lie_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            value_reg <= in_value;
        case (cmd.op)
            lie_pkg::DP_SCAN_UPD:
            begin
                if (i_reg == '0)
                begin
                    lo1_reg <= a_reg;
                    hi1_reg <= a_reg;
                    lo2_reg <= b_reg;
                    hi2_reg <= b_reg;
                end
                else
                begin
                    if (LEN_W'(i_reg) < len1_reg)
                    begin
                        if (a_reg < lo1_reg)
                            lo1_reg <= a_reg;
                        if (a_reg > hi1_reg)
                            hi1_reg <= a_reg;
                    end
                    if (LEN_W'(i_reg) < len2_reg)
                    begin
                        if (b_reg < lo2_reg)
                            lo2_reg <= b_reg;
                        if (b_reg > hi2_reg)
                            hi2_reg <= b_reg;
                    end
                end
            end
            lie_pkg::DP_CAP_LO:
            begin
                lo1_reg <= a_reg;
                lo2_reg <= b_reg;
            end
            lie_pkg::DP_CAP_HI:
            begin
                hi1_reg <= a_reg;
                hi2_reg <= b_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_index_reg  <= cmd.out_from_store ? s_ext[lie_pkg::INDEX_W-1:0] : '0;
            out_count_reg  <= found_reg;
            out_status_reg <= cmd.out_status;
        end
    end

    assign flags.len1_zero = (len1_reg == '0);
    assign flags.len2_zero = (len2_reg == '0);
    assign flags.len1_full = (len1_reg == LEN_FULL);
    assign flags.len2_full = (len2_reg == LEN_FULL);
    assign flags.in_range  = (value_reg < lie_pkg::VALUE_W'(stored_cnt));
    assign flags.overlap   = (hi2_reg >= lo1_reg) && (lo2_reg <= hi1_reg);
    assign flags.scan_last = (LEN_W'(i_reg) == max_len_m1);
    assign flags.pair_last = i_last && j_last;
    assign flags.mrg_done  = !adv_j && i_last;
    assign flags.overflow  = ovf_reg;

    assign out_index  = out_index_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

/* rtl/lie_ctrl.sv */
// Controller of the list intersection engine: search mode register, item
// sequencing state machine and output valid. Uses lie_pkg.
`default_nettype none

module lie_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lie_pkg::SEARCH_W-1:0]   cfg_wr_data,
    input  wire logic                           s_tvalid,
    input  wire logic [lie_pkg::MODE_W-1:0]     s_mode,
    output logic                                s_tready,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output lie_pkg::dp_cmd_t                    cmd,
    input  wire lie_pkg::dp_flags_t             flags
);

    lie_pkg::ctrl_state_t           state_reg, state_next;
    logic [lie_pkg::MODE_W-1:0]     mode_reg;
    logic [lie_pkg::SEARCH_W-1:0]   search_reg;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept, slot_free;

    assign s_tready  = (state_reg == lie_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lie_pkg::S_IDLE;
            mode_reg      <= '0;
            search_reg    <= lie_pkg::SM_UNSORTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                mode_reg <= s_mode;
            if (cfg_wr_en)
                search_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd                = '0;
        cmd.op             = lie_pkg::DP_NOP;
        cmd.out_status     = lie_pkg::ST_OK;
        cmd.capture        = accept;
        out_valid_next     = m_tready ? 1'b0 : out_valid_reg;

        case (state_reg)
            lie_pkg::S_IDLE:
                if (accept)
                    state_next = lie_pkg::S_EXEC;
            lie_pkg::S_EXEC:
            begin
                case (mode_reg)
                    lie_pkg::MODE_LOAD_FIRST:
                        if (slot_free)
                        begin
                            cmd.op         = lie_pkg::DP_LOAD_FIRST;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = flags.len1_full ? lie_pkg::ST_FULL
                                                             : lie_pkg::ST_OK;
                            state_next     = lie_pkg::S_IDLE;
                        end
                    lie_pkg::MODE_LOAD_SECOND:
                        if (slot_free)
                        begin
                            cmd.op         = lie_pkg::DP_LOAD_SECOND;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = flags.len2_full ? lie_pkg::ST_FULL
                                                             : lie_pkg::ST_OK;
                            state_next     = lie_pkg::S_IDLE;
                        end
                    lie_pkg::MODE_RUN:
                    begin
                        cmd.op = lie_pkg::DP_RUN_INIT;
                        if (flags.len1_zero || flags.len2_zero)
                            state_next = lie_pkg::S_RESP_RUN;
                        else
                        begin
                            case (search_reg)
                                lie_pkg::SM_UNSORTED:    state_next = lie_pkg::S_SCAN_RD;
                                lie_pkg::SM_BOTH_SORTED: state_next = lie_pkg::S_RD_ZERO;
                                default:                 state_next = lie_pkg::S_RESP_BAD;
                            endcase
                        end
                    end
                    lie_pkg::MODE_READ:
                    begin
                        cmd.op     = lie_pkg::DP_READ;
                        state_next = lie_pkg::S_RD_WAIT;
                    end
                    lie_pkg::MODE_CLEAR:
                        if (slot_free)
                        begin
                            cmd.op       = lie_pkg::DP_CLEAR;
                            cmd.out_load = 1'b1;
                            state_next   = lie_pkg::S_IDLE;
                        end
                    default:
                        if (slot_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = lie_pkg::S_IDLE;
                        end
                endcase
            end
            lie_pkg::S_RD_WAIT:
                if (slot_free)
                begin
                    cmd.out_load       = 1'b1;
                    cmd.out_from_store = flags.in_range;
                    cmd.out_status     = flags.in_range ? lie_pkg::ST_OK : lie_pkg::ST_RANGE;
                    state_next         = lie_pkg::S_IDLE;
                end
            lie_pkg::S_SCAN_RD:
            begin
                cmd.op     = lie_pkg::DP_SCAN_RD;
                state_next = lie_pkg::S_SCAN_UPD;
            end
            lie_pkg::S_SCAN_UPD:
            begin
                cmd.op     = lie_pkg::DP_SCAN_UPD;
                state_next = flags.scan_last ? lie_pkg::S_OVL_CHK : lie_pkg::S_SCAN_RD;
            end
            lie_pkg::S_RD_ZERO:
            begin
                cmd.op     = lie_pkg::DP_RD_ZERO;
                state_next = lie_pkg::S_CAP_LO;
            end
            lie_pkg::S_CAP_LO:
            begin
                cmd.op     = lie_pkg::DP_CAP_LO;
                state_next = lie_pkg::S_CAP_HI;
            end
            lie_pkg::S_CAP_HI:
            begin
                cmd.op     = lie_pkg::DP_CAP_HI;
                state_next = lie_pkg::S_OVL_CHK;
            end
            lie_pkg::S_OVL_CHK:
            begin
                if (!flags.overlap)
                    state_next = lie_pkg::S_RESP_RUN;
                else if (search_reg == lie_pkg::SM_BOTH_SORTED)
                    state_next = lie_pkg::S_MRG_RD;
                else
                    state_next = lie_pkg::S_PAIR_RD;
            end
            lie_pkg::S_PAIR_RD:
            begin
                cmd.op     = lie_pkg::DP_PAIR_RD;
                state_next = lie_pkg::S_PAIR_CMP;
            end
            lie_pkg::S_PAIR_CMP:
            begin
                cmd.op     = lie_pkg::DP_PAIR_CMP;
                state_next = flags.pair_last ? lie_pkg::S_RESP_RUN : lie_pkg::S_PAIR_RD;
            end
            lie_pkg::S_MRG_RD:
            begin
                cmd.op     = lie_pkg::DP_MRG_RD;
                state_next = lie_pkg::S_MRG_CMP;
            end
            lie_pkg::S_MRG_CMP:
            begin
                cmd.op     = lie_pkg::DP_MRG_CMP;
                state_next = flags.mrg_done ? lie_pkg::S_RESP_RUN : lie_pkg::S_MRG_RD;
            end
            lie_pkg::S_RESP_RUN:
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = flags.overflow ? lie_pkg::ST_OVERFLOW : lie_pkg::ST_OK;
                    state_next     = lie_pkg::S_IDLE;
                end
            lie_pkg::S_RESP_BAD:
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = lie_pkg::ST_BAD_MODE;
                    state_next     = lie_pkg::S_IDLE;
                end
            default:
                state_next = lie_pkg::S_IDLE;
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

endmodule

`default_nettype wire

/* rtl/list_intersection_engine_core.sv */
// Top level of the list intersection engine: controller plus datapath,
// stream ports and the search mode register port. Uses lie_pkg, lie_ctrl, lie_datapath.
//
//   Channel  | Signals                             | Direction | Payload
//   ---------+-------------------------------------+-----------+--------------------------
//   config   | cfg_wr_en, cfg_wr_data              | in        | search_mode
//   s (in)   | s_tvalid, s_tready, s_tdata, s_tuser| in        | value / mode
//   m (out)  | m_tvalid, m_tready, m_tdata, m_tuser| out       | match_index, count / status
//
// Loads, clear and unused modes finish in S_EXEC, a read also passes S_RD_WAIT.
// A run in search mode 0 scans both lists for their ranges, then compares every
// pair; in search mode 2 it merges the sorted lists. Every step is one access on the
// single read port of each list memory plus a compare on the registered data.
// Reset clears lengths, match count, overflow and control; memories are not cleared.
// The output register lets the next item be accepted while a result waits;
// an item that is done holds in the controller until the output register frees.
`default_nettype none

module list_intersection_engine_core #(
    parameter int MAX_LEN  = lie_pkg::MAX_LEN_DEF,
    parameter int ID_WIDTH = lie_pkg::ID_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // search mode register write
    input  wire logic                           cfg_wr_en,
    input  wire logic [lie_pkg::SEARCH_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // [31:0] value
    input  wire logic [lie_pkg::MODE_W-1:0]     s_tuser,   // [2:0] mode
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,   // [9:0] match_index, [30:10] match_count, [31] zero
    output logic [lie_pkg::STATUS_W-1:0]        m_tuser    // [2:0] status
);

    lie_pkg::dp_cmd_t              cmd;
    lie_pkg::dp_flags_t            flags;
    logic [lie_pkg::INDEX_W-1:0]   out_index;
    logic [lie_pkg::COUNT_W-1:0]   out_count;
    lie_pkg::status_t              out_status;

    // Sequencing: accept, step the run, hold the result until the output frees.
    lie_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_mode      (s_tuser),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .flags       (flags)
    );

    // Lists, match store, counters and the result register.
    lie_datapath #(
        .MAX_LEN  (MAX_LEN),
        .ID_WIDTH (ID_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_value   (s_tdata),
        .flags      (flags),
        .out_index  (out_index),
        .out_count  (out_count),
        .out_status (out_status)
    );

    // Pack the result fields, lowest field in the lowest bits, pad to a byte.
    assign m_tdata = {1'b0, out_count, out_index};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

/* rtl/lie_checker.sv */
// Port-level checker for the list intersection engine core, bound to the top.
// Uses assert_macros.svh and lie_pkg.
`default_nettype none
`include "assert_macros.svh"

module lie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // A stalled result keeps its valid.
    `ASSERT_CLKD(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `ASSERT_CLKD(a_out_stable, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result payload changed while stalled")

    // Only an ok result carries a match position.
    `ASSERT_CLKD(a_index_zero, clk, rst_n, m_tvalid && m_tuser != lie_pkg::ST_OK |-> m_tdata[9:0] == 10'd0, "nonzero index on error result")

    // The block works on one item at a time.
    `ASSERT_CLKD(a_one_item, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "ready held right after accept")

    // No result is shown while reset is held.
    `ASSERT_CLK_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind list_intersection_engine_core lie_checker u_lie_checker (.*);

`default_nettype wire
